// ----- rtl/ppds_pkg.sv -----
package ppds_pkg;

	// Pulses examined for a sync pulse at the start of a capture
	localparam int unsigned SYNC_WINDOW = 10;
	// Width of the shift register that collects decoded bits
	localparam int unsigned DATA_BITS   = 32;

	localparam int unsigned PULSE_W = 20;
	localparam int unsigned TIME_W  = 16;
	localparam int unsigned WORD_W  = 32;
	localparam int unsigned COUNT_W = 16;
	localparam int unsigned POS_W   = 4;

	// Sync must be narrower than this
	localparam logic [PULSE_W-1:0] SYNC_LIMIT = PULSE_W'(100000);
	// Frames with more bits than this are flagged valid
	localparam logic [COUNT_W-1:0] MIN_FRAME_BITS = COUNT_W'(4);
	localparam logic [POS_W-1:0]   POS_MAX        = '1;
	localparam logic [POS_W-1:0]   SYNC_POS_LIMIT = POS_W'(SYNC_WINDOW);
	localparam logic [COUNT_W-1:0] COUNT_MAX      = '1;

	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = TIME_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SHORT_TIME = 1'b0,
		REG_LONG_TIME  = 1'b1
	} cfg_reg_t;

	localparam logic [TIME_W-1:0] SHORT_TIME_RESET = TIME_W'(300);
	localparam logic [TIME_W-1:0] LONG_TIME_RESET  = TIME_W'(900);

	typedef struct packed {
		logic [PULSE_W-1:0] pulse_width;
		logic               last_pulse;
	} pulse_t;

	typedef struct packed {
		logic [WORD_W-1:0]  data_word;
		logic [COUNT_W-1:0] bits_decoded;
		logic               frame_valid;
	} frame_t;

endpackage

// ----- rtl/ppds_if.sv -----
interface ppds_pulse_if;
	logic              valid;
	logic              ready;
	ppds_pkg::pulse_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface ppds_frame_if;
	logic              valid;
	logic              ready;
	ppds_pkg::frame_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/pwm_pulse_decoder_with_sync_top.sv -----
// Pulse-width decoder with sync detection. Each pulse transaction carries one
// captured pulse width and a last-pulse flag. Among the first ten pulses of a
// capture, the first one wider than 3*long_time and narrower than 100000 is
// taken as sync and restarts decoding with the next pulse; without sync,
// decoding starts at the first pulse. A pulse within 50..180 percent of
// short_time shifts in a 0 (short band tested first), one within that band of
// long_time shifts in a 1, and any other pulse stops decoding until a later
// sync inside the window. On the last pulse one frame transaction is emitted
// (data_word, saturating bits_decoded, frame_valid when more than four bits)
// and the capture state clears. A pulse is registered on acceptance and
// decoded there, and the frame register loads when the last pulse leaves the
// input register, so a frame is offered once its last pulse has passed the
// input register and the frame register; one pulse is accepted every cycle,
// and the input stalls only while a finished frame waits in the output
// register and a further last pulse is ready to replace it. Write short_time
// (index 0) and long_time (index 1) only while no capture is in flight.
module pwm_pulse_decoder_with_sync_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [ppds_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ppds_pkg::CFG_DATA_W-1:0]     cfg_data,
	ppds_pulse_if.sink                          pulse_ch,
	ppds_frame_if.source                        frame_ch
);

	// Configuration
	logic [ppds_pkg::TIME_W-1:0] short_time_q;
	logic [ppds_pkg::TIME_W-1:0] long_time_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_time_q <= ppds_pkg::SHORT_TIME_RESET;
			long_time_q  <= ppds_pkg::LONG_TIME_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ppds_pkg::REG_SHORT_TIME: short_time_q <= cfg_data;
				ppds_pkg::REG_LONG_TIME:  long_time_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register
	logic             valid_s1;
	ppds_pkg::pulse_t pulse_s1;
	logic             out_valid_q;
	logic             advance_s1;

	// Hold a last pulse while the previous frame has not been taken
	assign advance_s1 = valid_s1 &&
		(!pulse_s1.last_pulse || !out_valid_q || frame_ch.ready);
	assign pulse_ch.ready = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pulse_ch.ready) begin
			valid_s1 <= pulse_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pulse_ch.valid && pulse_ch.ready) begin
			pulse_s1 <= pulse_ch.data;
		end
	end

	// Capture state
	logic                             sync_seen_q;
	logic [ppds_pkg::POS_W-1:0]       pulse_position_q;
	logic                             decode_stopped_q;
	logic [ppds_pkg::DATA_BITS-1:0]   shift_word_q;
	logic [ppds_pkg::COUNT_W-1:0]     bit_total_q;

	// Band limits: lo = t/2, and p <= floor(9t/5) is the same as 5p <= 9t
	logic [ppds_pkg::PULSE_W+2:0]     pulse_x5;
	logic [ppds_pkg::TIME_W+3:0]      short_x9;
	logic [ppds_pkg::TIME_W+3:0]      long_x9;
	logic [ppds_pkg::TIME_W+1:0]      long_x3;
	logic                             short_hit;
	logic                             long_hit;
	logic                             sync_hit;

	assign pulse_x5 = {3'b000, pulse_s1.pulse_width} + {1'b0, pulse_s1.pulse_width, 2'b00};
	assign short_x9 = {4'b0000, short_time_q} + {1'b0, short_time_q, 3'b000};
	assign long_x9  = {4'b0000, long_time_q} + {1'b0, long_time_q, 3'b000};
	assign long_x3  = {2'b00, long_time_q} + {1'b0, long_time_q, 1'b0};

	assign short_hit = (pulse_s1.pulse_width >= ppds_pkg::PULSE_W'(short_time_q >> 1)) &&
		(pulse_x5 <= (ppds_pkg::PULSE_W+3)'(short_x9));
	assign long_hit  = (pulse_s1.pulse_width >= ppds_pkg::PULSE_W'(long_time_q >> 1)) &&
		(pulse_x5 <= (ppds_pkg::PULSE_W+3)'(long_x9));
	assign sync_hit  = !sync_seen_q && (pulse_position_q < ppds_pkg::SYNC_POS_LIMIT) &&
		(pulse_s1.pulse_width > ppds_pkg::PULSE_W'(long_x3)) &&
		(pulse_s1.pulse_width < ppds_pkg::SYNC_LIMIT);

	logic                             sync_seen_d;
	logic                             decode_stopped_d;
	logic [ppds_pkg::DATA_BITS-1:0]   shift_word_d;
	logic [ppds_pkg::COUNT_W-1:0]     bit_total_d;
	logic [ppds_pkg::COUNT_W-1:0]     bit_total_inc;

	assign bit_total_inc = (bit_total_q == ppds_pkg::COUNT_MAX) ?
		bit_total_q : bit_total_q + ppds_pkg::COUNT_W'(1);

	always_comb begin
		sync_seen_d      = sync_seen_q;
		decode_stopped_d = decode_stopped_q;
		shift_word_d     = shift_word_q;
		bit_total_d      = bit_total_q;
		priority if (sync_hit) begin
			// Sync: drop everything decoded so far
			sync_seen_d      = 1'b1;
			decode_stopped_d = 1'b0;
			shift_word_d     = '0;
			bit_total_d      = '0;
		end else if (!decode_stopped_q) begin
			priority if (short_hit) begin
				shift_word_d = {shift_word_q[ppds_pkg::DATA_BITS-2:0], 1'b0};
				bit_total_d  = bit_total_inc;
			end else if (long_hit) begin
				shift_word_d = {shift_word_q[ppds_pkg::DATA_BITS-2:0], 1'b1};
				bit_total_d  = bit_total_inc;
			end else begin
				decode_stopped_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_seen_q      <= 1'b0;
			pulse_position_q <= '0;
			decode_stopped_q <= 1'b0;
			shift_word_q     <= '0;
			bit_total_q      <= '0;
		end else if (advance_s1) begin
			if (pulse_s1.last_pulse) begin
				// End of capture: clear for the next one
				sync_seen_q      <= 1'b0;
				pulse_position_q <= '0;
				decode_stopped_q <= 1'b0;
				shift_word_q     <= '0;
				bit_total_q      <= '0;
			end else begin
				sync_seen_q      <= sync_seen_d;
				decode_stopped_q <= decode_stopped_d;
				shift_word_q     <= shift_word_d;
				bit_total_q      <= bit_total_d;
				if (pulse_position_q != ppds_pkg::POS_MAX) begin
					pulse_position_q <= pulse_position_q + ppds_pkg::POS_W'(1);
				end
			end
		end
	end

	// Output register
	ppds_pkg::frame_t frame_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1 && pulse_s1.last_pulse) begin
			out_valid_q <= 1'b1;
		end else if (frame_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && pulse_s1.last_pulse) begin
			frame_q.data_word    <= ppds_pkg::WORD_W'(shift_word_d);
			frame_q.bits_decoded <= bit_total_d;
			frame_q.frame_valid  <= bit_total_d > ppds_pkg::MIN_FRAME_BITS;
		end
	end

	assign frame_ch.valid = out_valid_q;
	assign frame_ch.data  = frame_q;

	// Checks
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance_s1) |-> (out_valid_q && !frame_ch.ready && pulse_s1.last_pulse))
		else $error("input stage stalled without a waiting frame");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(advance_s1 && pulse_s1.last_pulse) |=>
		(bit_total_q == '0 && pulse_position_q == '0 && !sync_seen_q && !decode_stopped_q))
		else $error("capture state not cleared after last pulse");

	a_frame_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (frame_q.frame_valid ==
		(frame_q.bits_decoded > ppds_pkg::MIN_FRAME_BITS)))
		else $error("frame_valid disagrees with bits_decoded");

	a_sync_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(advance_s1 && sync_hit && !pulse_s1.last_pulse) |=>
		(bit_total_q == '0 && sync_seen_q))
		else $error("sync did not restart decoding");

endmodule
